// ===== rtl/llq_pkg.sv =====
// types and constants shared by the linked list queue manager
package llq_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned ID_W     = 6;
  localparam int unsigned ID_SPACE = 1 << ID_W;

  localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
  localparam logic [OP_W-1:0] OP_REM = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] entry_id;
  } in_t;

  typedef struct packed {
    logic            item_valid;
    logic [ID_W-1:0] item_id;
    logic            found;
    logic            now_empty;
  } out_t;

  typedef struct packed {
    logic            enq;
    logic            rem;
    logic            shift;
    logic            loop;
    logic [ID_W-1:0] id;
  } cell_cmd_t;

  typedef struct packed {
    logic found;
    logic placed;
    logic hit_last;
  } carry_t;

endpackage

// ===== rtl/llq_cell.sv =====
// one queue slot: holds an id, passes the scan token and its flags to the right
module llq_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  llq_pkg::cell_cmd_t         cmd,
  input  logic                       tok_i,
  input  llq_pkg::carry_t            car_i,
  input  logic                       nxt_vld_i,
  input  logic [llq_pkg::ID_W-1:0]   nxt_id_i,
  output logic                       tok_o,
  output llq_pkg::carry_t            car_o,
  output logic                       vld_o,
  output logic [llq_pkg::ID_W-1:0]   id_o
);
  import llq_pkg::*;

  logic            vld_r;
  logic            vld_nxt;
  logic [ID_W-1:0] id_r;
  logic [ID_W-1:0] id_nxt;
  logic            tok_r;
  carry_t          car_r;
  logic            match;
  logic            at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      tok_r <= 1'b0;
      car_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      tok_r <= tok_i;
      car_r <= car_i;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

  always_comb begin
    match   = vld_r && (id_r == cmd.id);
    at_last = match && !nxt_vld_i;
    vld_nxt = vld_r;
    id_nxt  = id_r;
    car_o   = car_r;
    if (cmd.shift) begin
      vld_nxt = nxt_vld_i;
      id_nxt  = nxt_id_i;
    end else if (tok_r && cmd.enq) begin
      if (car_r.found) begin
        // drop everything behind a re-queued id
        vld_nxt = 1'b0;
      end else if (match) begin
        car_o.found    = 1'b1;
        car_o.hit_last = at_last;
      end else if (!vld_r && !car_r.placed) begin
        vld_nxt      = 1'b1;
        id_nxt       = cmd.id;
        car_o.placed = 1'b1;
      end
    end else if (tok_r && cmd.rem) begin
      if (at_last && cmd.loop) begin
        // tail repeats itself: only the repeat goes
        car_o.found    = 1'b1;
        car_o.hit_last = 1'b1;
      end else if (car_r.found || match) begin
        vld_nxt     = nxt_vld_i;
        id_nxt      = nxt_id_i;
        car_o.found = 1'b1;
      end
    end
  end

  assign tok_o = tok_r;
  assign vld_o = vld_r;
  assign id_o  = id_r;

endmodule

// ===== rtl/linked_list_fifo_with_remove.sv =====
// linked list queue manager: a row of slots kept in queue order, head in slot 0
// N = min(POOL_ENTRIES, 64) slots; a scan token moves one slot per cycle
// enqueue and remove with an in-range id pass the token over every slot, then ST_DONE
// dequeue reads slot 0 and shifts in ST_DEQ; others go to ST_DONE; one request at a time
// synchronous active-low reset empties the queue, no clearing pass needed
module linked_list_fifo_with_remove #(
  parameter int unsigned POOL_ENTRIES = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  llq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output llq_pkg::out_t out_data
);
  import llq_pkg::*;

  localparam int unsigned N_CELLS = (POOL_ENTRIES < ID_SPACE) ? POOL_ENTRIES : ID_SPACE;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PASS = 2'd1;
  localparam logic [1:0] ST_DEQ  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]      state_r;
  logic [1:0]      state_nxt;
  logic [OP_W-1:0] op_r;
  logic [OP_W-1:0] op_nxt;
  logic [ID_W-1:0] id_r;
  logic [ID_W-1:0] id_nxt;
  logic            loop_r;
  logic            loop_nxt;
  out_t            res_r;
  out_t            res_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  out_t            out_data_r;
  out_t            out_data_nxt;

  logic            accept;
  logic            in_rng;
  logic            start;
  cell_cmd_t       cmd;

  logic            tok_w [0:N_CELLS];
  carry_t          car_w [0:N_CELLS];
  logic            vld_w [0:N_CELLS];
  logic [ID_W-1:0] id_w  [0:N_CELLS];

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign in_rng    = (32'(in_data.entry_id) < POOL_ENTRIES);
  assign start     = accept && in_rng &&
                     ((in_data.op == OP_ENQ) || (in_data.op == OP_REM));
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cmd.enq   = (state_r == ST_PASS) && (op_r == OP_ENQ);
  assign cmd.rem   = (state_r == ST_PASS) && (op_r == OP_REM);
  assign cmd.shift = (state_r == ST_DEQ) && !(loop_r && !vld_w[1]);
  assign cmd.loop  = loop_r;
  assign cmd.id    = id_r;

  assign tok_w[0]       = start;
  assign car_w[0]       = '0;
  assign vld_w[N_CELLS] = 1'b0;
  assign id_w[N_CELLS]  = '0;

  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    llq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .tok_i     (tok_w[i]),
      .car_i     (car_w[i]),
      .nxt_vld_i (vld_w[i+1]),
      .nxt_id_i  (id_w[i+1]),
      .tok_o     (tok_w[i+1]),
      .car_o     (car_w[i+1]),
      .vld_o     (vld_w[i]),
      .id_o      (id_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      loop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loop_r      <= loop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    loop_nxt      = loop_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt  = in_data.op;
          id_nxt  = in_data.entry_id;
          res_nxt = '0;
          if (start) begin
            state_nxt = ST_PASS;
          end else if (in_data.op == OP_DEQ) begin
            state_nxt = ST_DEQ;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_PASS: begin
        if (tok_w[N_CELLS]) begin
          res_nxt.found = (op_r == OP_REM) && car_w[N_CELLS].found;
          if (op_r == OP_ENQ) begin
            loop_nxt = car_w[N_CELLS].hit_last;
          end else begin
            loop_nxt = loop_r && !car_w[N_CELLS].hit_last;
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DEQ: begin
        res_nxt.item_valid = vld_w[0];
        res_nxt.item_id    = vld_w[0] ? id_w[0] : '0;
        if (vld_w[0] && loop_r && !vld_w[1]) begin
          loop_nxt = 1'b0;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt            = res_r;
          out_data_nxt.now_empty  = !vld_w[0];
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
